// File: hw/rtl/pcrms_pkg.sv
// pcrms_pkg: shared constants, codes and control structs for the per-channel RMS block.
// Used by pcrms_ctrl, pcrms_dp and per_channel_running_rms. No dependencies.
`timescale 1ns / 1ps

package pcrms_pkg;

    localparam int NUM_CHANNELS_DEF = 8;

    // field widths
    localparam int SAMPLE_W = 24;
    localparam int CH_W     = 3;
    localparam int RMS_W    = 23;
    localparam int SUM_W    = 64;
    localparam int CNT_W    = 32;
    localparam int SQ_W     = 2 * SAMPLE_W;
    localparam int ROOT_W   = SUM_W / 2;
    localparam int SQR_W    = ROOT_W + 2;

    localparam int DIV_STEPS  = SUM_W;
    localparam int SQRT_STEPS = SUM_W / 2;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam logic [RMS_W-1:0] LIMIT_RESET = 23'd160000;
    localparam logic [RMS_W-1:0] RMS_MAX     = {RMS_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX     = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX     = {CNT_W{1'b1}};

    // input item kinds
    localparam logic CMD_ACCUM = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // register index (paddr[2])
    localparam logic REG_OVERLOAD_LIMIT = 1'b0;

    typedef struct packed {
        logic load_in;
        logic clear_all;
        logic mem_rd;
        logic update;
        logic div_step;
        logic sqrt_step;
        logic out_load;
    } pcrms_cmd_t;

    typedef struct packed {
        logic special;   // clear or out-of-range channel: no arithmetic
        logic out_free;  // output register can take a result this cycle
    } pcrms_stat_t;

endpackage

// File: hw/rtl/pcrms_ctrl.sv
// pcrms_ctrl: sequencer for one item: read, update, divide, square root, result.
// Depends on pcrms_pkg.
`timescale 1ns / 1ps

module pcrms_ctrl
    import pcrms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  pcrms_stat_t stat,
    output pcrms_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_UPD,
        S_DIV,
        S_SQRT,
        S_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
                if (in_valid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.mem_rd    = 1'b1;
                cmd.clear_all = stat.special;
                state_next    = stat.special ? S_OUT : S_UPD;
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == STEP_W'(SQRT_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                cmd.out_load = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// File: hw/rtl/pcrms_dp.sv
// pcrms_dp: channel store, squarer, bit-serial divider and square root, output register.
// Depends on pcrms_pkg; driven by pcrms_ctrl commands.
`timescale 1ns / 1ps

module pcrms_dp
    import pcrms_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  pcrms_cmd_t          cmd,
    input  logic [SAMPLE_W-1:0] in_tdata,
    input  logic [CH_W:0]       in_tuser,
    input  logic [RMS_W-1:0]    limit,
    output pcrms_stat_t         stat,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,
    output logic [CH_W-1:0]     m_tuser
);

    localparam int CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [7:0] NCH_W8 = 8'(NUM_CHANNELS);

    // item registers
    logic                       kind_reg;
    logic [CH_W-1:0]            ch_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [SQ_W-1:0]            sq_reg;

    // channel store
    logic [SUM_W-1:0]        sum_mem [NUM_CHANNELS];
    logic [CNT_W-1:0]        cnt_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] valid_reg;
    logic [SUM_W-1:0]        rd_sum_reg;
    logic [CNT_W-1:0]        rd_cnt_reg;
    logic                    rd_vld_reg;

    // arithmetic
    logic [SUM_W-1:0]  dvd_reg;
    logic [CNT_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [SQR_W-1:0]  sqr_reg;
    logic [ROOT_W-1:0] root_reg;
    logic              sat_reg;
    logic              cnt_zero_reg;

    // output
    logic              m_tvalid_reg;
    logic [31:0]       m_tdata_reg;
    logic [CH_W-1:0]   m_tuser_reg;

    logic [CH_AW-1:0]    idx;
    logic                in_range;
    logic [SAMPLE_W-1:0] mag;
    logic [SUM_W-1:0]    old_sum, new_sum;
    logic [CNT_W-1:0]    old_cnt, new_cnt;
    logic [SUM_W:0]      add_sum;
    logic                sat_old, sat_new;
    logic [CNT_W:0]      div_t, div_d;
    logic                div_ge;
    logic [SQR_W+1:0]    sq_t, sq_trial, sq_d;
    logic                sq_ge;
    logic [ROOT_W-1:0]   rms_full;
    logic [RMS_W-1:0]    rms_clamp;
    logic                overload;

    assign idx      = CH_AW'(ch_reg);
    assign in_range = {5'd0, ch_reg} < NCH_W8;
    assign stat.special  = (kind_reg == CMD_CLEAR) || !in_range;
    assign stat.out_free = !m_tvalid_reg || m_tready;

    assign mag = sample_reg[SAMPLE_W-1] ? SAMPLE_W'(-sample_reg) : SAMPLE_W'(sample_reg);

    // accumulate with saturation; a channel frozen at either maximum stays put
    always_comb
    begin
        old_sum = rd_vld_reg ? rd_sum_reg : '0;
        old_cnt = rd_vld_reg ? rd_cnt_reg : '0;
        sat_old = (old_sum == SUM_MAX) || (old_cnt == CNT_MAX);
        add_sum = {1'b0, old_sum} + {{(SUM_W + 1 - SQ_W){1'b0}}, sq_reg};
        if (sat_old)
        begin
            new_sum = old_sum;
            new_cnt = old_cnt;
        end
        else
        begin
            new_sum = add_sum[SUM_W] ? SUM_MAX : add_sum[SUM_W-1:0];
            new_cnt = old_cnt + 1'b1;
        end
        sat_new = (new_sum == SUM_MAX) || (new_cnt == CNT_MAX);
    end

    // restoring divide, one quotient bit per step; quotient shifts into dvd_reg
    assign div_t  = {rem_reg, dvd_reg[SUM_W-1]};
    assign div_ge = div_t >= {1'b0, dvs_reg};
    assign div_d  = div_t - {1'b0, dvs_reg};

    // digit-by-digit square root, two radicand bits per step
    assign sq_t     = {sqr_reg, dvd_reg[SUM_W-1:SUM_W-2]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_ge    = sq_t >= sq_trial;
    assign sq_d     = sq_t - sq_trial;

    assign rms_full  = cnt_zero_reg ? '0 : root_reg;
    assign rms_clamp = (rms_full > ROOT_W'(RMS_MAX)) ? RMS_MAX : rms_full[RMS_W-1:0];
    assign overload  = rms_full > ROOT_W'(limit);

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            kind_reg   <= in_tuser[0];
            ch_reg     <= in_tuser[CH_W:1];
            sample_reg <= in_tdata;
        end
        if (cmd.mem_rd)
        begin
            rd_sum_reg <= sum_mem[idx];
            rd_cnt_reg <= cnt_mem[idx];
            rd_vld_reg <= valid_reg[idx];
            sq_reg     <= SQ_W'(mag) * SQ_W'(mag);
        end
        if (cmd.update)
        begin
            sum_mem[idx] <= new_sum;
            cnt_mem[idx] <= new_cnt;
            dvd_reg      <= new_sum;
            dvs_reg      <= new_cnt;
            rem_reg      <= '0;
            sqr_reg      <= '0;
            root_reg     <= '0;
            sat_reg      <= sat_new;
            cnt_zero_reg <= (new_cnt == '0);
        end
        if (cmd.div_step)
        begin
            rem_reg <= div_ge ? div_d[CNT_W-1:0] : div_t[CNT_W-1:0];
            dvd_reg <= {dvd_reg[SUM_W-2:0], div_ge};
        end
        if (cmd.sqrt_step)
        begin
            sqr_reg  <= sq_ge ? sq_d[SQR_W-1:0] : sq_t[SQR_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], sq_ge};
            dvd_reg  <= {dvd_reg[SUM_W-3:0], 2'b00};
        end
        if (cmd.out_load)
        begin
            if (kind_reg == CMD_CLEAR)
            begin
                m_tuser_reg <= '0;
                m_tdata_reg <= '0;
            end
            else if (!in_range)
            begin
                m_tuser_reg <= ch_reg;
                m_tdata_reg <= '0;
            end
            else
            begin
                m_tuser_reg <= ch_reg;
                m_tdata_reg <= {7'd0, sat_reg, overload, rms_clamp};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_all && (kind_reg == CMD_CLEAR))
            begin
                valid_reg <= '0;
            end
            else if (cmd.update)
            begin
                valid_reg[idx] <= 1'b1;
            end
            if (cmd.out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: hw/rtl/per_channel_running_rms.sv
// per_channel_running_rms: top level, APB limit register, controller and datapath.
// Depends on pcrms_pkg, pcrms_ctrl, pcrms_dp.
//
//  port group | role          | payload
//  s_*        | item in       | tdata: sample[23:0]; tuser: cmd[0], channel[3:1]
//  m_*        | result out    | tdata: rms[22:0], overload[23], saturated[24]; tuser: out_channel
//  p*         | APB register  | 0x0 overload_limit[22:0]
//
// A sample item holds the sequencer through taking the item, the store read and squaring,
// the saturating update, the one-bit-per-cycle divider, the two-bits-per-cycle square
// root and the load of the output register. Clear and out-of-range items skip the
// update, divider and square root.
// The next item is taken while a result waits in the output register; a stalled output
// holds the sequencer only when a second result is ready. Reset and clear drop the
// per-channel valid bits.
`timescale 1ns / 1ps

module per_channel_running_rms
    import pcrms_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,   // sample[23:0]
    input  logic [CH_W:0]       s_tuser,   // cmd[0], channel[3:1]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,   // rms[22:0], overload[23], saturated[24], zero
    output logic [CH_W-1:0]     m_tuser,   // out_channel[2:0]
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [RMS_W-1:0] limit_reg;
    pcrms_cmd_t       cmd;
    pcrms_stat_t      stat;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_OVERLOAD_LIMIT) ? {9'd0, limit_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_OVERLOAD_LIMIT))
        begin
            limit_reg <= pwdata[RMS_W-1:0];
        end
    end

    pcrms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pcrms_dp #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_tdata (s_tdata),
        .in_tuser (s_tuser),
        .limit    (limit_reg),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    // one item at a time through the sequencer
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while sequencer busy");

    // overload with an unclamped rms must exceed the limit
    a_overload_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[23] && (m_tdata[22:0] != RMS_MAX)) |-> (m_tdata[22:0] > limit_reg))
        else $error("overload set at or below limit");

    // channels beyond the store report an all-zero result
    a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && ({5'd0, m_tuser} >= 8'(NUM_CHANNELS))) |-> (m_tdata == 32'd0))
        else $error("nonzero result for out-of-range channel");
`endif

endmodule
